### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, register codes and types of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // widest cell address over the supported geometry range (64 x 256)
    localparam int ADDR_MAX_W = 14;

    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [CELL_W-1:0]     wdata;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } mem_req_t;

endpackage

### rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// valid/ready channels for console requests and results
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output action, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input action, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CELL_W-1:0]     read_data;
    logic [tcw_pkg::POS_W-1:0]      cursor_pos;
    logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row;
    logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col;
    logic                           scrolled;

    modport source (output valid, output read_data, output cursor_pos, output cursor_row,
                    output cursor_col, output scrolled, input ready);
    modport sink   (input valid, input read_data, input cursor_pos, input cursor_row,
                    input cursor_col, input scrolled, output ready);
endinterface

### rtl/tcw_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcw_cfg_regs
// apb register file holding the foreground and background colors
// ----------------------------------------------------------------------------
module tcw_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [tcw_pkg::ATTR_W-1:0]         attr
);

    logic [tcw_pkg::COLOR_W-1:0] fg_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcw_pkg::FG_RESET;
            bg_reg <= tcw_pkg::BG_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == tcw_pkg::REG_FG)
            begin
                fg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
            end
            else
            begin
                bg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == tcw_pkg::REG_FG)
        begin
            prdata = tcw_pkg::APB_DATA_W'(fg_reg);
        end
        else
        begin
            prdata = tcw_pkg::APB_DATA_W'(bg_reg);
        end
    end

    assign attr = {bg_reg, fg_reg};

endmodule

### rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_screen_ram
#(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                        clk,
    input  tcw_pkg::mem_req_t           mem,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem_array [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem.we)
        begin
            mem_array[mem.waddr[ADDR_W-1:0]] <= mem.wdata;
        end
        if (mem.re)
        begin
            rdata_reg <= mem_array[mem.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq
// cursor state, item sequencer and the copy/clear sweep over the cell store
// ----------------------------------------------------------------------------
module tcw_seq
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    tcw_req_if.sink                     req,
    tcw_rsp_if.source                   rsp,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    output tcw_pkg::mem_req_t           mem,
    input  logic [tcw_pkg::CELL_W-1:0]  rdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int AMW        = tcw_pkg::ADDR_MAX_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              cp_valid_reg, cp_valid_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              res_scrolled_reg, res_scrolled_next;
    logic [tcw_pkg::CELL_W-1:0] res_data_reg, res_data_next;

    logic                          out_valid_reg, out_valid_next;
    logic [tcw_pkg::CELL_W-1:0]    out_data_reg, out_data_next;
    logic [tcw_pkg::POS_W-1:0]     out_pos_reg, out_pos_next;
    logic [tcw_pkg::ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [tcw_pkg::COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic                          out_scr_reg, out_scr_next;

    logic              accept;
    logic              line_break;
    logic              idx_ok;
    logic [ADDR_W-1:0] next_base;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign idx_ok    = (32'(req.cell_index) < CELL_COUNT);
    assign next_base = ADDR_W'(base_reg + ADDR_W'(COLUMNS));

    always_comb
    begin
        state_next        = state_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        pos_next          = pos_reg;
        base_next         = base_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        cp_valid_next     = cp_valid_reg;
        rd_ok_next        = rd_ok_reg;
        res_scrolled_next = res_scrolled_reg;
        res_data_next     = res_data_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_data_next     = out_data_reg;
        out_pos_next      = out_pos_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scr_next      = out_scr_reg;
        line_break        = 1'b0;
        mem.we            = 1'b0;
        mem.waddr         = AMW'(pos_reg);
        mem.wdata         = {attr, req.char_code};
        mem.re            = 1'b0;
        mem.raddr         = AMW'(req.cell_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == tcw_pkg::ACT_READ)
                    begin
                        rd_ok_next = idx_ok;
                        mem.re     = idx_ok;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        res_data_next     = '0;
                        res_scrolled_next = 1'b0;
                        state_next        = ST_DONE;
                        if (req.char_code == tcw_pkg::NEWLINE_CODE)
                        begin
                            line_break = 1'b1;
                        end
                        else
                        begin
                            mem.we = 1'b1;
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                line_break = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        if (line_break)
                        begin
                            col_next = '0;
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                base_next         = ADDR_W'(LAST_BASE);
                                pos_next          = ADDR_W'(LAST_BASE);
                                res_scrolled_next = 1'b1;
                                src_next          = CNT_W'(COLUMNS);
                                dst_next          = '0;
                                cp_valid_next     = 1'b0;
                                state_next        = ST_COPY;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                base_next = next_base;
                                pos_next  = next_base;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_data_next     = rd_ok_reg ? rdata : '0;
                res_scrolled_next = 1'b0;
                state_next        = ST_DONE;
            end
            ST_COPY:
            begin
                // read one row ahead, write the previous read back one row up
                mem.raddr = AMW'(src_reg);
                mem.waddr = AMW'(dst_reg);
                mem.wdata = rdata;
                mem.re    = (src_reg < CNT_W'(CELL_COUNT));
                mem.we    = cp_valid_reg;
                if (mem.re)
                begin
                    src_next = src_reg + 1'b1;
                end
                if (cp_valid_reg)
                begin
                    dst_next = dst_reg + 1'b1;
                end
                cp_valid_next = mem.re;
                if (!mem.re && !cp_valid_reg)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.waddr = AMW'(dst_reg);
                mem.wdata = '0;
                dst_next  = dst_reg + 1'b1;
                if (dst_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = res_scrolled_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_pos_next   = tcw_pkg::POS_W'(pos_reg);
                    out_row_next   = tcw_pkg::ROW_OUT_W'(row_reg);
                    out_col_next   = tcw_pkg::COL_OUT_W'(col_reg);
                    out_scr_next   = res_scrolled_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            col_reg          <= '0;
            row_reg          <= '0;
            pos_reg          <= '0;
            base_reg         <= '0;
            src_reg          <= '0;
            dst_reg          <= '0;
            cp_valid_reg     <= 1'b0;
            rd_ok_reg        <= 1'b0;
            res_scrolled_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            pos_reg          <= pos_next;
            base_reg         <= base_next;
            src_reg          <= src_next;
            dst_reg          <= dst_next;
            cp_valid_reg     <= cp_valid_next;
            rd_ok_reg        <= rd_ok_next;
            res_scrolled_reg <= res_scrolled_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        out_data_reg <= out_data_next;
        out_pos_reg  <= out_pos_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_scr_reg  <= out_scr_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.cursor_pos = out_pos_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.scrolled   = out_scr_reg;

    a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == ADDR_W'(base_reg + ADDR_W'(col_reg)))
        else $error("linear cursor out of step with row base and column");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS - 1) || col_reg == COL_W'(COLUMNS - 1))
        else $error("cursor column beyond last column");

    a_copy_below_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && mem.we) |-> (CNT_W'(dst_reg) < src_reg))
        else $error("scroll copy writes at or above its read pointer");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_scrolled_reg) |->
            (row_reg == ROW_W'(ROWS - 1) && col_reg == '0))
        else $error("scrolled item left cursor off the last row start");

endmodule

### rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// text console engine: cell store, cursor, scroll and apb color registers
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        action, char_code, cell_index
//  rsp      out  valid/ready        read_data, cursor_pos, cursor_row, cursor_col, scrolled
//  apb      in   psel/penable/pready fg_color at 0x0, bg_color at 0x4
//
//  a character or newline passes through ST_DONE, a cell read also through ST_READ (registered ram read)
//  a scroll walks the store through the ram read and write ports: it copies each row up one row,
//  then clears the last row, with req.ready low
//  after reset a clearing pass over all ROWS*COLUMNS cells runs with req.ready low
//  a stalled rsp holds one result while the next item is taken in
// ----------------------------------------------------------------------------
module text_console_writer_top
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    tcw_req_if.sink                         req,
    tcw_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic [tcw_pkg::ATTR_W-1:0] attr;
    tcw_pkg::mem_req_t          mem;
    logic [tcw_pkg::CELL_W-1:0] rdata;

    tcw_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tcw_screen_ram
    #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W ($clog2(CELL_COUNT))
    )
    u_ram
    (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );

    tcw_seq
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .attr  (attr),
        .mem   (mem),
        .rdata (rdata)
    );

endmodule
